// ===== rtl/bbfa_pkg.sv =====
`timescale 1ns / 1ps
package bbfa_pkg;
  localparam logic [31:0] P      = 32'd2013265921;
  localparam logic [31:0] MU     = 32'h88000001;
  localparam logic [30:0] ONE_M  = 31'd268435454;
  localparam logic [30:0] R2_M   = 31'd1172168163;
  localparam logic [30:0] HALF_E = 31'd1006632960;
  localparam logic [30:0] INV_E  = 31'd2013265919;
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_TOM = 3'd3,
    OP_FROMM = 3'd4, OP_INV = 3'd5, OP_POW = 3'd6, OP_SQT = 3'd7
  } op_t;

  typedef struct packed {
    logic        err;
    logic        is_pow;
    logic        sqt;
    logic [2:0]  mode;
    logic [30:0] a;
    logic [30:0] b;
    logic [30:0] e;
  } job_t;
endpackage

// ===== rtl/bbfa_front.sv =====
`timescale 1ns / 1ps
module bbfa_front #(
  parameter int unsigned QDEPTH = bbfa_pkg::QDEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [95:0]    in_tdata,
  output logic           job_valid,
  input  logic           job_ready,
  output bbfa_pkg::job_t job
);
  localparam int unsigned AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  bbfa_pkg::job_t q_r [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  bbfa_pkg::job_t cls;
  logic [2:0]  md;
  logic [30:0] a, b, e;
  logic push, pop;

  assign md = in_tdata[2:0];
  assign a  = in_tdata[33:3];
  assign b  = in_tdata[64:34];
  assign e  = in_tdata[95:65];

  always_comb begin
    cls.mode   = md;
    cls.a      = a;
    cls.b      = b;
    cls.e      = (md == bbfa_pkg::OP_INV) ? bbfa_pkg::INV_E :
                 (md == bbfa_pkg::OP_SQT) ? bbfa_pkg::HALF_E : e;
    cls.is_pow = (md == bbfa_pkg::OP_INV) || (md == bbfa_pkg::OP_POW) ||
                 (md == bbfa_pkg::OP_SQT);
    cls.sqt    = (md == bbfa_pkg::OP_SQT);
    cls.err    = ({1'b0, a} >= bbfa_pkg::P) ||
                 ((md <= bbfa_pkg::OP_MUL) && ({1'b0, b} >= bbfa_pkg::P)) ||
                 ((md == bbfa_pkg::OP_INV) && (a == 31'd0));
  end

  assign in_tready = (cnt_r < (AW+1)'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign job_valid = (cnt_r != '0);
  assign pop       = job_valid && job_ready;
  assign job       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== rtl/bbfa_mmul.sv =====
`timescale 1ns / 1ps
module bbfa_mmul (
  input  logic        clk,
  input  logic        start,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic [30:0] z,
  output logic        done
);
  logic [63:0] prod_r;
  logic [31:0] t_r;
  logic [63:0] prod2_r;
  logic [63:0] u_r;
  logic [63:0] d;
  logic [31:0] hi;
  logic s1_r, s2_r, s3_r;

  always_ff @(posedge clk) begin
    s1_r    <= start;
    s2_r    <= s1_r;
    s3_r    <= s2_r;
    prod_r  <= 64'(x) * 64'(y);
    t_r     <= 32'(prod_r[31:0] * bbfa_pkg::MU);
    prod2_r <= prod_r;
    u_r     <= 64'(t_r) * 64'(bbfa_pkg::P);
  end

  assign d    = prod2_r - u_r;
  assign hi   = (prod2_r < u_r) ? d[63:32] + bbfa_pkg::P : d[63:32];
  assign z    = hi[30:0];
  assign done = s3_r;
endmodule

// ===== rtl/bbfa_back.sv =====
`timescale 1ns / 1ps
module bbfa_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  output logic           job_ready,
  input  bbfa_pkg::job_t job,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [39:0]    out_tdata
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_PMUL, S_PSQ, S_DONE} st_t;
  st_t st_r;
  logic [30:0] acc_r, sq_r, e_r, res_r;
  logic sqt_r, resid_r, err_r, ov_r, stb_r;
  logic [31:0] mx_r, my_r;
  logic [30:0] mz;
  logic mdone;
  logic [31:0] sum, dif;

  bbfa_mmul u_mul (.clk(clk), .start(stb_r), .x(mx_r), .y(my_r), .z(mz), .done(mdone));

  assign job_ready = (st_r == S_IDLE) && !ov_r;
  assign sum = {1'b0, job.a} + {1'b0, job.b};
  assign dif = {1'b0, job.a} - {1'b0, job.b};
  assign out_tvalid = ov_r;
  assign out_tdata = {7'd0, err_r, resid_r, res_r};

  always_ff @(posedge clk) begin
    stb_r <= 1'b0;
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0;
    end else begin
      if (ov_r && out_tready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (job_valid && !ov_r) begin
            err_r <= job.err; resid_r <= 1'b0; sqt_r <= job.sqt;
            if (job.err) begin
              res_r <= '0; ov_r <= 1'b1;
            end else if (job.is_pow) begin
              acc_r <= bbfa_pkg::ONE_M; sq_r <= job.a; e_r <= job.e;
              if (job.e == '0) begin
                res_r <= bbfa_pkg::ONE_M; resid_r <= job.sqt; ov_r <= 1'b1;
              end else if (job.e[0]) begin
                mx_r <= {1'b0, bbfa_pkg::ONE_M}; my_r <= {1'b0, job.a};
                stb_r <= 1'b1; st_r <= S_PMUL;
              end else begin
                mx_r <= {1'b0, job.a}; my_r <= {1'b0, job.a};
                stb_r <= 1'b1; st_r <= S_PSQ;
              end
            end else begin
              case (job.mode)
                bbfa_pkg::OP_ADD: begin
                  res_r <= (sum >= bbfa_pkg::P) ? 31'(sum - bbfa_pkg::P) : sum[30:0];
                  ov_r <= 1'b1;
                end
                bbfa_pkg::OP_SUB: begin
                  res_r <= (job.a >= job.b) ? dif[30:0] : 31'(dif + bbfa_pkg::P);
                  ov_r <= 1'b1;
                end
                bbfa_pkg::OP_MUL: begin
                  mx_r <= {1'b0, job.a}; my_r <= {1'b0, job.b};
                  stb_r <= 1'b1; st_r <= S_MUL;
                end
                bbfa_pkg::OP_TOM: begin
                  mx_r <= {1'b0, job.a}; my_r <= {1'b0, bbfa_pkg::R2_M};
                  stb_r <= 1'b1; st_r <= S_MUL;
                end
                default: begin
                  mx_r <= {1'b0, job.a}; my_r <= 32'd1;
                  stb_r <= 1'b1; st_r <= S_MUL;
                end
              endcase
            end
          end
        end
        S_MUL: begin
          if (mdone) begin
            res_r <= mz; ov_r <= 1'b1; st_r <= S_IDLE;
          end
        end
        S_PMUL: begin
          if (mdone) begin
            acc_r <= mz;
            if (e_r[30:1] == '0) begin
              res_r <= mz; resid_r <= sqt_r && (mz == bbfa_pkg::ONE_M);
              ov_r <= 1'b1; st_r <= S_IDLE;
            end else begin
              mx_r <= {1'b0, sq_r}; my_r <= {1'b0, sq_r};
              stb_r <= 1'b1; st_r <= S_PSQ;
            end
          end
        end
        S_PSQ: begin
          if (mdone) begin
            sq_r <= mz; e_r <= e_r >> 1;
            if (e_r[1]) begin
              mx_r <= {1'b0, acc_r}; my_r <= {1'b0, mz};
              stb_r <= 1'b1; st_r <= S_PMUL;
            end else begin
              mx_r <= {1'b0, mz}; my_r <= {1'b0, mz};
              stb_r <= 1'b1; st_r <= S_PSQ;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/babybear_field_alu.sv =====
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit up)
// in_     | in  | mode[2:0], operand_a[33:3], operand_b[64:34], exponent[95:65]
// out_    | out | result[30:0], is_residue[31], error[32]
// add, sub and errors finish without the multiplier; mul and conversions take one Montgomery multiply.
// power runs a square-and-multiply loop of Montgomery multiplies, up to 61 multiplies;
// inverse and square test are powers with fixed exponents.
// A two-entry queue parts intake from the multiplier loop; rst_n is synchronous.
module babybear_field_alu #(
  parameter int unsigned QDEPTH = bbfa_pkg::QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // mode, operand_a, operand_b, exponent
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // result, is_residue, error
);
  logic jv, jr;
  bbfa_pkg::job_t job;

  bbfa_front #(.QDEPTH(QDEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .job_valid(jv), .job_ready(jr), .job(job));

  bbfa_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(jv), .job_ready(jr), .job(job),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
endmodule

// ===== tb/tb_babybear_field_alu.sv =====
`timescale 1ns / 1ps
module tb_babybear_field_alu;

  localparam logic [31:0] MODP = 32'd2013265921;
  localparam logic [31:0] MUQ = 32'h88000001;
  localparam logic [30:0] MONT_ONE = 31'd268435454;
  localparam logic [30:0] EXP_HALF = 31'd1006632960;
  localparam logic [30:0] EXP_INV = 31'd2013265919;

  typedef struct packed {
    logic [30:0]   e;
    logic [30:0]   b;
    logic [30:0]   a;
    bbfa_pkg::op_t mode;
  } alu_item_t;

  typedef struct {
    logic [30:0] result;
    logic        resid;
    logic        err;
  } alu_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  alu_item_t pending_items[$];
  alu_res_t  expected_results[$];
  int        mismatches = 0;
  int        in_wait = 0;
  int        out_wait = 0;
  int        hold_off = 0;
  bit        drain_pause = 1'b0;
  int        accepted = 0;

  babybear_field_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] reduce(logic [63:0] x);
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] d;
    logic [31:0] hi;
    t = (x * {32'd0, MUQ}) & 64'hFFFF_FFFF;
    u = t * {32'd0, MODP};
    d = x - u;
    hi = d[63:32];
    if (x < u) hi = hi + MODP;
    return hi;
  endfunction

  function automatic logic [31:0] mmul(logic [31:0] a, logic [31:0] b);
    return reduce({32'd0, a} * {32'd0, b});
  endfunction

  function automatic logic [31:0] mpow(logic [31:0] base, logic [30:0] e);
    logic [31:0] acc;
    logic [31:0] sq;
    acc = {1'b0, MONT_ONE};
    sq = base;
    while (e != '0) begin
      if (e[0]) acc = mmul(acc, sq);
      e = e >> 1;
      if (e != '0) sq = mmul(sq, sq);
    end
    return acc;
  endfunction

  function automatic alu_res_t field_result(alu_item_t it);
    alu_res_t r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] v;
    logic [63:0] w;
    a = {1'b0, it.a};
    b = {1'b0, it.b};
    v = '0;
    r.resid = 1'b0;
    r.err = 1'b0;
    if (a >= MODP || (it.mode <= bbfa_pkg::OP_MUL && b >= MODP)) begin
      r.err = 1'b1;
    end else begin
      case (it.mode)
        bbfa_pkg::OP_ADD: begin
          v = a + b;
          if (v >= MODP) v = v - MODP;
        end
        bbfa_pkg::OP_SUB: v = (a >= b) ? a - b : a + MODP - b;
        bbfa_pkg::OP_MUL: v = mmul(a, b);
        bbfa_pkg::OP_TOM: begin
          w = {a, 32'd0} % {32'd0, MODP};
          v = w[31:0];
        end
        bbfa_pkg::OP_FROMM: v = reduce({32'd0, a});
        bbfa_pkg::OP_INV: begin
          if (a == '0) r.err = 1'b1;
          else v = mpow(a, EXP_INV);
        end
        bbfa_pkg::OP_POW: v = mpow(a, it.e);
        default: begin
          v = mpow(a, EXP_HALF);
          r.resid = (v[30:0] == MONT_ONE);
        end
      endcase
    end
    r.result = v[30:0];
    return r;
  endfunction

  function automatic logic [30:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 31'd0;
      1: return MODP[30:0] - 31'd1;
      2: return 31'($urandom_range(MODP, 32'h7FFF_FFFF));
      3: return MONT_ONE;
      default: return 31'($urandom_range(0, MODP - 1));
    endcase
  endfunction

  task automatic add_item(bbfa_pkg::op_t m, logic [30:0] a, logic [30:0] b,
                          logic [30:0] e);
    alu_item_t it;
    it.mode = m;
    it.a = a;
    it.b = b;
    it.e = e;
    pending_items.push_back(it);
  endtask

  always @(posedge clk) begin
    alu_item_t it;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        it = alu_item_t'(in_tdata);
        expected_results.push_back(field_result(it));
        accepted <= accepted + 1;
        if (accepted == 600) drain_pause = 1'b1;
      end
      if (drain_pause && expected_results.size() == 0) drain_pause = 1'b0;
      if (!(in_tvalid && !in_tready)) begin
        if (in_wait > 0) begin
          in_wait <= in_wait - 1;
          in_tvalid <= 1'b0;
        end else if (!drain_pause && pending_items.size() > 0) begin
          in_tdata <= {pending_items.pop_front()};
          in_tvalid <= 1'b1;
          in_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    alu_res_t exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item %h", out_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tdata[30:0] !== exp_r.result || out_tdata[31] !== exp_r.resid ||
              out_tdata[32] !== exp_r.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp res=%0d resid=%b err=%b got res=%0d resid=%b err=%b",
                       exp_r.result, exp_r.resid, exp_r.err,
                       out_tdata[30:0], out_tdata[31], out_tdata[32]);
          end
        end
      end
      if (accepted == 300 && hold_off == 0) hold_off <= 3000;
      if (hold_off > 1) begin
        hold_off <= hold_off - 1;
        out_tready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready)
          out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
    end
  end

  initial begin
    int n;
    bbfa_pkg::op_t m;
    add_item(bbfa_pkg::OP_ADD, 31'd0, 31'd0, 31'd0);
    add_item(bbfa_pkg::OP_ADD, MODP[30:0] - 31'd1, MODP[30:0] - 31'd1, 31'd0);
    add_item(bbfa_pkg::OP_SUB, 31'd0, MODP[30:0] - 31'd1, 31'd0);
    add_item(bbfa_pkg::OP_SUB, 31'd5, 31'd5, 31'd0);
    add_item(bbfa_pkg::OP_MUL, MODP[30:0] - 31'd1, MODP[30:0] - 31'd1, 31'h7FFF_FFFF);
    add_item(bbfa_pkg::OP_MUL, 31'd0, 31'h7FFF_FFFF, 31'd0);
    add_item(bbfa_pkg::OP_TOM, MODP[30:0] - 31'd1, 31'h7FFF_FFFF, 31'd0);
    add_item(bbfa_pkg::OP_TOM, 31'd1, 31'd0, 31'd0);
    add_item(bbfa_pkg::OP_FROMM, MONT_ONE, 31'd0, 31'd0);
    add_item(bbfa_pkg::OP_FROMM, MODP[30:0], 31'd0, 31'd0);
    add_item(bbfa_pkg::OP_INV, 31'd0, 31'd0, 31'd0);
    add_item(bbfa_pkg::OP_INV, MONT_ONE, 31'd0, 31'd0);
    add_item(bbfa_pkg::OP_INV, MODP[30:0] - 31'd1, 31'd0, 31'd0);
    add_item(bbfa_pkg::OP_POW, 31'd0, 31'd0, 31'd0);
    add_item(bbfa_pkg::OP_POW, 31'd12345, 31'd0, 31'h7FFF_FFFF);
    add_item(bbfa_pkg::OP_POW, 31'h7FFF_FFFF, 31'd0, 31'd3);
    add_item(bbfa_pkg::OP_SQT, 31'd0, 31'd0, 31'd0);
    add_item(bbfa_pkg::OP_SQT, MONT_ONE, 31'd0, 31'd0);
    add_item(bbfa_pkg::OP_SQT, MODP[30:0] - 31'd1, 31'd0, 31'd0);
    add_item(bbfa_pkg::OP_ADD, 31'd1, MODP[30:0], 31'd0);
    for (n = 0; n < 1100; n++) begin
      m = bbfa_pkg::op_t'($urandom_range(0, 7));
      add_item(m, rand_elem(), rand_elem(),
               ($urandom_range(0, 4) == 0) ? 31'($urandom_range(0, 8))
                                           : 31'($urandom));
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !in_tvalid);
    @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/bbfa_pkg.sv
rtl/bbfa_front.sv
rtl/bbfa_mmul.sv
rtl/bbfa_back.sv
rtl/babybear_field_alu.sv
tb/tb_babybear_field_alu.sv
